@@ sv/eust_pkg.sv @@
`default_nettype none

package eust_pkg;

   localparam int DAY_W  = 16;
   localparam int YEAR_W = 8;
   localparam int REM_W  = 10;
   localparam int LOW_W  = 7;
   localparam int SOD_W  = REM_W + LOW_W;
   localparam int TBL_DEPTH = 1 << YEAR_W;

   // The seconds count is split as seconds = low7 + 128 * x, and 86400 = 128 * 675.
   localparam int X_W = 32 - LOW_W;

   // Exact floor(x / 675) for 25-bit x through a rounded-up reciprocal.
   localparam int          DIV675_SHIFT = 35;
   localparam int          DIV675_W     = 26;
   localparam logic [DIV675_W-1:0] DIV675_MUL = 26'd50903317;
   localparam logic [REM_W-1:0]    DAY_UNITS  = 10'd675;

   // Exact floor(day / 365) for 16-bit day through a rounded-up reciprocal.
   localparam int          DIV365_SHIFT = 24;
   localparam logic [DAY_W-1:0] DIV365_MUL = 16'd45965;

   localparam logic [SOD_W-1:0] START_SOD = 17'd7200;
   localparam logic [SOD_W-1:0] END_SOD   = 17'd10800;

   localparam int MARCH_LAST_DOY   = 89;
   localparam int OCTOBER_LAST_DOY = 303;

   typedef logic [DAY_W-1:0] day_tbl_type [0:TBL_DEPTH-1];

   typedef enum logic [1:0] {
      TBL_YEAR_BASE = 2'd0,
      TBL_START     = 2'd1,
      TBL_END       = 2'd2
   } tbl_kind_type;

   // Stage result between the year search and the window check.
   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [YEAR_W-1:0] year_idx;
      logic              ge_start_hour;
      logic              lt_end_hour;
   } cal_type;

   // Walks the years from 1970 and tracks the leap rule and the weekday with
   // wrapping counters, so no division is needed to build the tables.
   function automatic day_tbl_type build_table(input tbl_kind_type kind);
      day_tbl_type tbl;
      int d;
      int m4;
      int m100;
      int m400;
      int wd;
      int leap;
      int ws;
      int we;
      d    = 0;
      m4   = 2;
      m100 = 70;
      m400 = 370;
      wd   = 4;
      for (int n = 0; n < TBL_DEPTH; n++) begin
         leap = (m4 == 0 && (m100 != 0 || m400 == 0)) ? 1 : 0;
         // Weekday offset of the last day of March and of October, Sunday at zero.
         ws = wd + (MARCH_LAST_DOY % 7) + leap;
         if (ws >= 7) begin
            ws = ws - 7;
         end
         we = wd + (OCTOBER_LAST_DOY % 7) + leap;
         if (we >= 7) begin
            we = we - 7;
         end
         unique case (kind)
            TBL_YEAR_BASE: tbl[n] = 16'(d);
            TBL_START:     tbl[n] = 16'(d + MARCH_LAST_DOY + leap - ws);
            TBL_END:       tbl[n] = 16'(d + OCTOBER_LAST_DOY + leap - we);
            default:       tbl[n] = '0;
         endcase
         d  = d + 365 + leap;
         wd = wd + 1 + leap;
         if (wd >= 7) begin
            wd = wd - 7;
         end
         m4   = (m4 == 3) ? 0 : m4 + 1;
         m100 = (m100 == 99) ? 0 : m100 + 1;
         m400 = (m400 == 399) ? 0 : m400 + 1;
      end
      return tbl;
   endfunction

   localparam day_tbl_type YEAR_BASE_TBL = build_table(TBL_YEAR_BASE);
   localparam day_tbl_type START_DAY_TBL = build_table(TBL_START);
   localparam day_tbl_type END_DAY_TBL   = build_table(TBL_END);

endpackage

`default_nettype wire

@@ sv/eust_year_locate.sv @@
`default_nettype none

module eust_year_locate (
   input  wire logic [eust_pkg::DAY_W-1:0]    day,
   input  wire logic [2*eust_pkg::DAY_W-1:0]  year_prod,
   input  wire logic [eust_pkg::X_W-1:0]      x,
   input  wire logic [eust_pkg::DIV675_W-1:0] day_units,
   input  wire logic [eust_pkg::LOW_W-1:0]    low_secs,
   output eust_pkg::cal_type                  cal
);
   import eust_pkg::*;

   logic [YEAR_W-1:0] year_guess;
   logic [DAY_W-1:0]  guess_base;
   logic [X_W-1:0]    rem_full;
   logic [SOD_W-1:0]  sod;

   // The reciprocal estimate day / 365 is never low and at most one year high.
   assign year_guess = year_prod[DIV365_SHIFT +: YEAR_W];
   assign guess_base = YEAR_BASE_TBL[year_guess];

   assign rem_full = x - day_units[X_W-1:0];
   assign sod      = {rem_full[REM_W-1:0], low_secs};

   always_comb begin
      cal.day           = day;
      cal.year_idx      = (guess_base > day) ? year_guess - 1'b1 : year_guess;
      cal.ge_start_hour = (sod >= START_SOD);
      cal.lt_end_hour   = (sod < END_SOD);
   end

endmodule

`default_nettype wire

@@ sv/eust_window.sv @@
`default_nettype none

module eust_window (
   input  wire eust_pkg::cal_type cal,
   output logic                   summer
);
   import eust_pkg::*;

   logic [DAY_W-1:0] start_day;
   logic [DAY_W-1:0] end_day;
   logic             after_start;
   logic             before_end;

   assign start_day = START_DAY_TBL[cal.year_idx];
   assign end_day   = END_DAY_TBL[cal.year_idx];

   assign after_start = (cal.day > start_day) || (cal.day == start_day && cal.ge_start_hour);
   assign before_end  = (cal.day < end_day) || (cal.day == end_day && cal.lt_end_hour);
   assign summer      = after_start && before_end;

endmodule

`default_nettype wire

@@ sv/eu_summer_time_detector.sv @@
// EU summer time detector.
// The req_ channel carries one timestamp per transaction, unsigned seconds
// since 1970-01-01 00:00. For each one the rsp_ channel returns one
// transaction: bit 0 is set when the timestamp lies between the last Sunday
// of March at 02:00 and the last Sunday of October at 03:00 of its year,
// and bits 2:1 give the zone offset, 2 hours in summer and 1 in winter.
// The datapath is a four-stage pipeline: reciprocal multiply for the day
// number, multiplies for the day remainder and the year estimate, year
// correction with the time of day, then the table lookup of both boundary
// days and the compare, which lands in the output register.
// Stages pass a timestamp on in order, and rsp_tvalid rises when its
// result is in the output register, which holds it until taken. With
// rsp_tready high, one timestamp is accepted every cycle. Each stage holds
// its item only while the stage after it is full and not moving, so a stall
// on rsp_tready fills the empty stages first and then deasserts req_tready;
// nothing is dropped or repeated. A synchronous reset empties all stages.
`default_nettype none

module eu_summer_time_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [0] summer_active, [2:1] zone_offset_hours
);
   import eust_pkg::*;

   localparam int P1_W = X_W + DIV675_W;

   // Stage 1: day reciprocal product.
   logic              v1_ff, v1_in;
   logic [P1_W-1:0]   p1_ff;
   logic [X_W-1:0]    x1_ff;
   logic [LOW_W-1:0]  low1_ff;
   // Stage 2: day number products.
   logic                  v2_ff, v2_in;
   logic [DAY_W-1:0]      day2_ff;
   logic [DIV675_W-1:0]   units2_ff;
   logic [2*DAY_W-1:0]    yprod2_ff;
   logic [X_W-1:0]        x2_ff;
   logic [LOW_W-1:0]      low2_ff;
   // Stage 3: year and time of day.
   logic    v3_ff, v3_in;
   cal_type cal3_ff;
   cal_type cal3_in;
   // Stage 4: result register.
   logic v4_ff, v4_in;
   logic summer4_ff;
   logic summer4_in;

   logic rdy1, rdy2, rdy3, rdy4;
   logic [DAY_W-1:0] day1;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   assign day1 = p1_ff[DIV675_SHIFT +: DAY_W];

   eust_year_locate u_year_locate (
      .day       (day2_ff),
      .year_prod (yprod2_ff),
      .x         (x2_ff),
      .day_units (units2_ff),
      .low_secs  (low2_ff),
      .cal       (cal3_in)
   );

   eust_window u_window (
      .cal    (cal3_ff),
      .summer (summer4_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         p1_ff   <= P1_W'(req_tdata[31:LOW_W]) * P1_W'(DIV675_MUL);
         x1_ff   <= req_tdata[31:LOW_W];
         low1_ff <= req_tdata[LOW_W-1:0];
      end
      if (rdy2 && v1_ff) begin
         day2_ff   <= day1;
         units2_ff <= DIV675_W'(day1) * DIV675_W'(DAY_UNITS);
         yprod2_ff <= (2*DAY_W)'(day1) * (2*DAY_W)'(DIV365_MUL);
         x2_ff     <= x1_ff;
         low2_ff   <= low1_ff;
      end
      if (rdy3 && v2_ff) begin
         cal3_ff <= cal3_in;
      end
      if (rdy4 && v3_ff) begin
         summer4_ff <= summer4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {5'b0, summer4_ff ? 2'd2 : 2'd1, summer4_ff};

endmodule

`default_nettype wire
